[design/msat_pkg.sv]
package msat_pkg;

   localparam int NUM_TIMERS_DEF = 16;
   localparam int TIME_BITS_DEF  = 48;
   localparam int SLEEP_BITS     = 20;
   localparam int FIRES_BITS     = 7;
   localparam logic [SLEEP_BITS-1:0] SLEEP_RESET = 20'd10000;
   localparam logic [FIRES_BITS-1:0] FIRES_RESET = 7'd64;

   typedef enum logic [2:0] {
      FUNC_TICK       = 3'd0,
      FUNC_ONCE       = 3'd1,
      FUNC_ONCE_AT    = 3'd2,
      FUNC_PERIODIC   = 3'd3,
      FUNC_PERIODIC_AT = 3'd4,
      FUNC_STOP       = 3'd5,
      FUNC_RESTART    = 3'd6,
      FUNC_QUERY      = 3'd7
   } func_type;

   typedef enum logic [1:0] {
      KIND_STATUS = 2'd0,
      KIND_FIRED  = 2'd1,
      KIND_DONE   = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_BAD_ARG   = 2'd1,
      ST_BAD_STATE = 2'd2
   } status_type;

   localparam logic CSR_SLEEP = 1'b0;
   localparam logic CSR_FIRES = 1'b1;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CMD_RD,
      S_CMD_EXEC,
      S_SCAN_RD,
      S_SCAN_EVAL,
      S_DIV,
      S_REARM,
      S_FIRE_OUT,
      S_DUE_RD,
      S_DUE_EVAL,
      S_OUT
   } state_type;

endpackage

[design/multi_slot_alarm_timer_unit.sv]
// Multi-slot alarm timer. Slot alarm times and periods live in two
// single-port-read RAMs with a registered read; active flags are
// flip-flops cleared by reset, so a slot never written reads as idle.
// A command transaction passes through accept, RAM read and execute and
// returns one status transaction. A tick walks the slots one by one: a slot
// that does not fire is read and evaluated, a one-shot firing then emits its
// result, and a periodic firing first re-arms from the catch-up remainder,
// which runs one bit per cycle in the shared divider. A second pass over the
// slots finds the next-due delay, and the tick then closes with one
// tick-finished result.
// Each firing and the closing tick-finished result wait while the output
// register still holds an unaccepted transaction; the next request is taken
// once the last response has been loaded into the output register.
module multi_slot_alarm_timer_unit #(
   parameter int NUM_TIMERS = msat_pkg::NUM_TIMERS_DEF,
   parameter int TIME_BITS  = msat_pkg::TIME_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_func,
   input  logic [3:0]  req_slot,
   input  logic [47:0] req_time_value,
   input  logic [47:0] req_period_value,
   input  logic [47:0] req_now_us,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [1:0]  rsp_status,
   output logic [3:0]  rsp_fired_slot,
   output logic [47:0] rsp_late_us,
   output logic        rsp_is_active,
   output logic [19:0] rsp_next_due_us,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [19:0] csr_data
);
   localparam int AW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int SW = $clog2(NUM_TIMERS + 1);
   localparam logic [TIME_BITS-1:0] TMAX = '1;

   msat_pkg::state_type state_ff, state_in;

   // configuration
   logic [msat_pkg::SLEEP_BITS-1:0] sleep_ff;
   logic [msat_pkg::FIRES_BITS-1:0] fires_lim_ff;

   // latched request
   logic [2:0]           func_ff, func_in;
   logic [3:0]           slot_ff, slot_in;
   logic [TIME_BITS-1:0] tv_ff, tv_in, pv_ff, pv_in, now_ff, now_in;

   // scan
   logic [SW-1:0]        idx_ff, idx_in;
   logic [msat_pkg::FIRES_BITS-1:0] fires_ff, fires_in;
   logic [TIME_BITS-1:0] late_ff, late_in;
   logic [TIME_BITS-1:0] due_ff, due_in;
   logic                 over_ff, over_in;

   logic [NUM_TIMERS-1:0] act_ff, act_in;

   // response register
   logic        rv_ff, rv_in;
   logic [1:0]  rk_ff, rk_in, rs_ff, rs_in;
   logic [3:0]  rslot_ff, rslot_in;
   logic [47:0] rlate_ff, rlate_in;
   logic        ract_ff, ract_in, rlast_ff, rlast_in;
   logic [19:0] rdue_ff, rdue_in;

   // memories
   logic                 a_we, p_we;
   logic [AW-1:0]        waddr, raddr;
   logic [TIME_BITS-1:0] a_wd, p_wd, a_rd, p_rd;

   msat_ram #(.WIDTH(TIME_BITS), .DEPTH(NUM_TIMERS)) u_alarm (
      .clock(clock), .wr_en(a_we), .wr_addr(waddr), .wr_data(a_wd),
      .rd_addr(raddr), .rd_data(a_rd));
   msat_ram #(.WIDTH(TIME_BITS), .DEPTH(NUM_TIMERS)) u_period (
      .clock(clock), .wr_en(p_we), .wr_addr(waddr), .wr_data(p_wd),
      .rd_addr(raddr), .rd_data(p_rd));

   logic                  div_start;
   logic                  div_busy;
   logic [TIME_BITS-1:0]  rem;

   msat_div #(.W(TIME_BITS)) u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend(late_ff), .divisor(p_rd), .busy(div_busy), .remainder(rem));

   function automatic logic [TIME_BITS-1:0] sat_add(
      input logic [TIME_BITS-1:0] a, input logic [TIME_BITS-1:0] b);
      logic [TIME_BITS:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[TIME_BITS] ? TMAX : s[TIME_BITS-1:0];
   endfunction

   logic                 slot_ok;
   logic [AW-1:0]        cur;
   logic [TIME_BITS-1:0] base, rearm, rel_alarm, dlt;
   logic                 rsp_free;

   assign slot_ok  = {28'd0, slot_ff} < 32'(NUM_TIMERS);
   assign cur      = idx_ff[AW-1:0];
   assign rsp_free = !rv_ff || rsp_ready;
   assign base     = now_ff - rem;
   assign rearm    = sat_add(base, p_rd);
   assign dlt      = a_rd - now_ff;

   always_comb begin
      state_in = state_ff;
      func_in = func_ff; slot_in = slot_ff;
      tv_in = tv_ff; pv_in = pv_ff; now_in = now_ff;
      idx_in = idx_ff; fires_in = fires_ff; late_in = late_ff;
      due_in = due_ff; over_in = over_ff; act_in = act_ff;
      rv_in = rv_ff && !rsp_ready;
      rk_in = rk_ff; rs_in = rs_ff; rslot_in = rslot_ff; rlate_in = rlate_ff;
      ract_in = ract_ff; rlast_in = rlast_ff; rdue_in = rdue_ff;
      a_we = 1'b0; p_we = 1'b0;
      a_wd = '0; p_wd = '0;
      waddr = slot_ff[AW-1:0];
      raddr = slot_ff[AW-1:0];
      div_start = 1'b0;
      rel_alarm = '0;
      req_ready = 1'b0;
      case (state_ff)
         msat_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               func_in = req_func;
               slot_in = req_slot;
               tv_in = TIME_BITS'(req_time_value);
               pv_in = TIME_BITS'(req_period_value);
               now_in = TIME_BITS'(req_now_us);
               idx_in = '0;
               fires_in = '0;
               over_in = 1'b0;
               state_in = (req_func == msat_pkg::FUNC_TICK) ?
                          msat_pkg::S_SCAN_RD : msat_pkg::S_CMD_RD;
            end
         end
         msat_pkg::S_CMD_RD: begin
            state_in = msat_pkg::S_CMD_EXEC;
         end
         msat_pkg::S_CMD_EXEC: begin
            if (rsp_free) begin
               rs_in = msat_pkg::ST_OK;
               if (!slot_ok) begin
                  rs_in = msat_pkg::ST_BAD_ARG;
               end else begin
                  case (func_ff)
                     msat_pkg::FUNC_ONCE, msat_pkg::FUNC_PERIODIC: begin
                        rel_alarm = sat_add(now_ff,
                           (func_ff == msat_pkg::FUNC_ONCE) ? tv_ff : pv_ff);
                        if (rel_alarm == '0) rs_in = msat_pkg::ST_BAD_ARG;
                        else if (act_ff[slot_ff[AW-1:0]])
                           rs_in = msat_pkg::ST_BAD_STATE;
                        else begin
                           a_we = 1'b1; p_we = 1'b1; a_wd = rel_alarm;
                           p_wd = (func_ff == msat_pkg::FUNC_ONCE) ? '0 : pv_ff;
                           act_in[slot_ff[AW-1:0]] = 1'b1;
                        end
                     end
                     msat_pkg::FUNC_ONCE_AT, msat_pkg::FUNC_PERIODIC_AT: begin
                        if (tv_ff <= now_ff) rs_in = msat_pkg::ST_BAD_ARG;
                        else if (act_ff[slot_ff[AW-1:0]])
                           rs_in = msat_pkg::ST_BAD_STATE;
                        else begin
                           a_we = 1'b1; p_we = 1'b1; a_wd = tv_ff;
                           p_wd = (func_ff == msat_pkg::FUNC_ONCE_AT) ? '0 : pv_ff;
                           act_in[slot_ff[AW-1:0]] = 1'b1;
                        end
                     end
                     msat_pkg::FUNC_STOP: begin
                        if (!act_ff[slot_ff[AW-1:0]]) rs_in = msat_pkg::ST_BAD_STATE;
                        else act_in[slot_ff[AW-1:0]] = 1'b0;
                     end
                     msat_pkg::FUNC_RESTART: begin
                        if (!act_ff[slot_ff[AW-1:0]] || tv_ff == '0)
                           rs_in = msat_pkg::ST_BAD_STATE;
                        else begin
                           a_we = 1'b1; a_wd = sat_add(now_ff, tv_ff);
                           // period read from RAM in the previous cycle
                           p_we = (p_rd != '0); p_wd = tv_ff;
                        end
                     end
                     default: rs_in = msat_pkg::ST_OK;
                  endcase
               end
               rv_in = 1'b1;
               rk_in = msat_pkg::KIND_STATUS;
               rslot_in = slot_ff;
               rlate_in = '0;
               ract_in = slot_ok ? act_in[slot_ff[AW-1:0]] : 1'b0;
               rdue_in = '0;
               rlast_in = 1'b1;
               state_in = msat_pkg::S_IDLE;
            end
         end
         msat_pkg::S_SCAN_RD: begin
            raddr = cur;
            if (idx_ff == SW'(NUM_TIMERS) || fires_ff >= fires_lim_ff) begin
               idx_in = '0;
               due_in = TIME_BITS'(sleep_ff);
               state_in = msat_pkg::S_DUE_RD;
            end else begin
               state_in = msat_pkg::S_SCAN_EVAL;
            end
         end
         msat_pkg::S_SCAN_EVAL: begin
            raddr = cur;
            late_in = now_ff - a_rd;
            if (!act_ff[cur] || a_rd > now_ff) begin
               idx_in = idx_ff + 1'b1;
               state_in = msat_pkg::S_SCAN_RD;
            end else if (p_rd != '0) begin
               state_in = msat_pkg::S_DIV;
            end else begin
               act_in[cur] = 1'b0;
               state_in = msat_pkg::S_FIRE_OUT;
            end
         end
         msat_pkg::S_DIV: begin
            raddr = cur;
            div_start = 1'b1;
            state_in = msat_pkg::S_REARM;
         end
         msat_pkg::S_REARM: begin
            raddr = cur;
            if (!div_busy) begin
               waddr = cur;
               a_we = 1'b1;
               a_wd = rearm;
               state_in = msat_pkg::S_FIRE_OUT;
            end
         end
         msat_pkg::S_FIRE_OUT: begin
            if (rsp_free) begin
               rv_in = 1'b1;
               rk_in = msat_pkg::KIND_FIRED;
               rs_in = msat_pkg::ST_OK;
               rslot_in = 4'(cur);
               rlate_in = 48'(late_ff);
               ract_in = act_ff[cur];
               rdue_in = '0;
               rlast_in = 1'b0;
               fires_in = fires_ff + 1'b1;
               idx_in = idx_ff + 1'b1;
               state_in = msat_pkg::S_SCAN_RD;
            end
         end
         msat_pkg::S_DUE_RD: begin
            raddr = cur;
            if (idx_ff == SW'(NUM_TIMERS) || over_ff) state_in = msat_pkg::S_OUT;
            else state_in = msat_pkg::S_DUE_EVAL;
         end
         msat_pkg::S_DUE_EVAL: begin
            raddr = cur;
            if (act_ff[cur]) begin
               if (a_rd <= now_ff) over_in = 1'b1;
               else if (dlt < due_ff) due_in = dlt;
            end
            idx_in = idx_ff + 1'b1;
            state_in = msat_pkg::S_DUE_RD;
         end
         msat_pkg::S_OUT: begin
            if (rsp_free) begin
               rv_in = 1'b1;
               rk_in = msat_pkg::KIND_DONE;
               rs_in = msat_pkg::ST_OK;
               rslot_in = '0;
               rlate_in = '0;
               ract_in = 1'b0;
               rdue_in = over_ff ? 20'd1 : due_ff[19:0];
               rlast_in = 1'b1;
               state_in = msat_pkg::S_IDLE;
            end
         end
         default: state_in = msat_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      func_ff <= func_in; slot_ff <= slot_in;
      tv_ff <= tv_in; pv_ff <= pv_in; now_ff <= now_in;
      idx_ff <= idx_in; fires_ff <= fires_in; late_ff <= late_in;
      due_ff <= due_in; over_ff <= over_in;
      rk_ff <= rk_in; rs_ff <= rs_in; rslot_ff <= rslot_in; rlate_ff <= rlate_in;
      ract_ff <= ract_in; rlast_ff <= rlast_in; rdue_ff <= rdue_in;
      if (reset) begin
         state_ff <= msat_pkg::S_IDLE;
         act_ff <= '0;
         rv_ff <= 1'b0;
         sleep_ff <= msat_pkg::SLEEP_RESET;
         fires_lim_ff <= msat_pkg::FIRES_RESET;
      end else begin
         state_ff <= state_in;
         act_ff <= act_in;
         rv_ff <= rv_in;
         if (csr_valid) begin
            if (csr_index == msat_pkg::CSR_SLEEP) sleep_ff <= csr_data;
            else fires_lim_ff <= csr_data[msat_pkg::FIRES_BITS-1:0];
         end
      end
   end

   assign csr_ready       = 1'b1;
   assign rsp_valid       = rv_ff;
   assign rsp_kind        = rk_ff;
   assign rsp_status      = rs_ff;
   assign rsp_fired_slot  = rslot_ff;
   assign rsp_late_us     = rlate_ff;
   assign rsp_is_active   = ract_ff;
   assign rsp_next_due_us = rdue_ff;
   assign rsp_last        = rlast_ff;

`ifndef SYNTH
   a_idle_only_req: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> state_ff == msat_pkg::S_IDLE)
      else $error("request taken outside idle");
   a_div_scan: assert property (@(posedge clock) disable iff (reset)
      div_busy |-> state_ff == msat_pkg::S_REARM)
      else $error("divider busy outside re-arm");
   a_fire_limit: assert property (@(posedge clock) disable iff (reset)
      rv_in && !rv_ff && rk_in == msat_pkg::KIND_FIRED |-> fires_ff < fires_lim_ff)
      else $error("fired past limit");
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rv_ff && rk_ff == msat_pkg::KIND_DONE |-> rlast_ff)
      else $error("tick finished without last");
`endif
endmodule

[design/msat_ram.sv]
module msat_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

[design/msat_div.sv]
// Restoring remainder unit, one quotient bit per cycle.
module msat_div #(
   parameter int W = 48
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] dividend,
   input  logic [W-1:0] divisor,
   output logic         busy,
   output logic [W-1:0] remainder
);
   localparam int CW = $clog2(W + 1);

   logic [W-1:0]  num_ff, num_in;
   logic [W-1:0]  den_ff, den_in;
   logic [W:0]    rem_ff, rem_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic [W:0]    trial;
   logic [W:0]    diff;

   always_comb begin
      trial   = {rem_ff[W-1:0], num_ff[W-1]};
      diff    = trial - {1'b0, den_ff};
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         num_in  = dividend;
         den_in  = divisor;
         rem_in  = '0;
         cnt_in  = CW'(W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[W-2:0], 1'b0};
         rem_in = diff[W] ? trial : diff;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   assign busy      = busy_ff;
   assign remainder = rem_ff[W-1:0];

`ifndef SYNTH
   a_cnt_idle: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> cnt_ff == '0 || $past(busy_ff))
      else $error("divider count left over");
   a_rem_lt: assert property (@(posedge clock) disable iff (reset)
      $fell(busy_ff) && den_ff != '0 |-> rem_ff < {1'b0, den_ff})
      else $error("remainder not below divisor");
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff)
      else $error("divider did not start");
`endif
endmodule
